>>> hw/rtl/pctc_pkg.sv
// Shared field widths, word codes and the result word type of the prefix code table codec.
package pctc_pkg;

    localparam int KIND_W   = 2;
    localparam int SYM_W    = 7;
    localparam int CODE_W   = 16;
    localparam int LEN_W    = 5;
    localparam int STATUS_W = 3;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = STATUS_W + 1;

    // input word kinds
    localparam logic [KIND_W-1:0] KIND_ADD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEC = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EOM = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_REJECT   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_UNCODED  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BADPATH  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_LEFTOVER = 3'd4;

    typedef struct packed {
        logic                symbol_valid;
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    out_code_length;
        logic [CODE_W-1:0]   out_code_word;
        logic [SYM_W-1:0]    out_symbol;
    } result_t;

endpackage

>>> hw/rtl/prefix_code_table_codec.sv
// Top level of the prefix code table codec: tree walker, node table and symbol code table.
//
// Usage
//   Input words arrive on s_*; s_tuser carries the kind (add rule, encode, decode one
//   bit, end of message), s_tdata the payload. Exactly one result word leaves on m_*
//   for every input word, in order: status and symbol_valid in m_tuser, the decoded
//   symbol and the encoded code in m_tdata.
//   One word is worked on at a time; s_tready is high only while the sequencer is idle.
//   An add rule that fails its field checks goes straight to the final state. The next
//   word can be taken in the cycle after the result is loaded. The node table has one
//   read port and one write port; an add rule walks the existing path one level per
//   cycle, then writes one new node per cycle.
//   Reset (aresetn low, synchronous) empties the tree to the root alone, forgets all
//   symbol codes and returns the decode cursor to the root. Node table entries are
//   tracked by the fill count, symbol codes by one valid flag per symbol: no sweep.
//   When m_tready stays low the result waits in the output register; the next input
//   word is still taken and worked on, and holds in the final state until the
//   register frees.
module prefix_code_table_codec #(
    parameter int NODE_COUNT    = 256,
    parameter int MAX_CODE_BITS = 16,
    parameter int SYMBOL_COUNT  = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [6:0] symbol, [22:7] code_word, [27:23] code_length, [28] stream_bit
    input  logic [pctc_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] kind
    input  logic [pctc_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [6:0] out_symbol, [22:7] out_code_word, [27:23] out_code_length
    output logic [pctc_pkg::M_TDATA_W-1:0]  m_tdata,
    // [2:0] status, [3] symbol_valid
    output logic [pctc_pkg::M_TUSER_W-1:0]  m_tuser
);
    import pctc_pkg::*;

    localparam int NW   = $clog2(NODE_COUNT);        // node index width
    localparam int CW   = $clog2(NODE_COUNT + 1);    // node count width
    localparam int SW   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int CAPW = ((CW > LEN_W) ? CW : LEN_W) + 1;
    localparam int MDW  = SYM_W + CODE_W + LEN_W;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ENC   = 4'd1;
    localparam logic [3:0] S_DEC1  = 4'd2;
    localparam logic [3:0] S_DEC2  = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_CAP   = 4'd5;
    localparam logic [3:0] S_LINK  = 4'd6;
    localparam logic [3:0] S_BUILD = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    typedef struct packed {
        logic [NW-1:0]    left;
        logic [NW-1:0]    right;
        logic             leaf;
        logic [SYM_W-1:0] sym;
    } node_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } code_ent_t;

    // input word fields
    logic [SYM_W-1:0]  in_symbol;
    logic [CODE_W-1:0] in_code_word;
    logic [LEN_W-1:0]  in_code_length;
    logic              in_stream_bit;

    assign in_symbol      = s_tdata[6:0];
    assign in_code_word   = s_tdata[22:7];
    assign in_code_length = s_tdata[27:23];
    assign in_stream_bit  = s_tdata[28];

    // control state
    logic [3:0]              state_reg, state_next;
    logic [CW-1:0]           nodes_used_reg, nodes_used_next;
    logic [NW-1:0]           cursor_reg, cursor_next;
    logic [NW-1:0]           root_left_reg, root_left_next;
    logic [NW-1:0]           root_right_reg, root_right_next;
    logic [SYMBOL_COUNT-1:0] sym_vld_reg, sym_vld_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // per-word working registers
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic [CODE_W-1:0] word_reg, word_next;
    logic [CODE_W-1:0] word_sh_reg, word_sh_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic              bit_reg, bit_next;
    logic [NW-1:0]     cur_reg, cur_next;
    node_t             par_reg, par_next;
    result_t           res_reg, res_next;
    result_t           out_reg, out_next;

    // node table, one read port and one write port
    node_t             node_mem [NODE_COUNT];
    node_t             node_rdata_reg;
    logic [NW-1:0]     node_raddr;
    logic              node_we;
    logic [NW-1:0]     node_waddr;
    node_t             node_wdata;

    // symbol code table
    code_ent_t         sym_mem [SYMBOL_COUNT];
    code_ent_t         sym_rdata_reg;
    logic [SW-1:0]     sym_raddr;
    logic              sym_we;
    logic [SW-1:0]     sym_idx;

    // shared walk datapath
    node_t             root_node;
    node_t             cur_node;
    logic              bit_sel;
    logic [NW-1:0]     child;
    logic [CAPW-1:0]   cap_sum;
    logic [NW-1:0]     new_idx;
    logic [NW-1:0]     next_new_idx;
    logic              in_bad_add;
    logic              sym_in_range;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - MDW){1'b0}},
                       out_reg.out_code_length, out_reg.out_code_word, out_reg.out_symbol};
    assign m_tuser  = {out_reg.symbol_valid, out_reg.status};

    assign sym_raddr = SW'({1'b0, in_symbol});
    assign sym_idx   = SW'({1'b0, sym_reg});
    assign sym_in_range = ({2'b00, sym_reg} < 9'(SYMBOL_COUNT));

    assign in_bad_add = (in_code_length == '0)
                     || ({1'b0, in_code_length} > 6'(MAX_CODE_BITS))
                     || ({2'b00, in_symbol} >= 9'(SYMBOL_COUNT));

    // root lives in flops; it is never a leaf
    assign root_node = '{left: root_left_reg, right: root_right_reg, leaf: 1'b0, sym: '0};
    assign cur_node  = (cur_reg == '0) ? root_node : node_rdata_reg;
    assign bit_sel   = (state_reg == S_DEC1) ? bit_reg : word_sh_reg[0];
    assign child     = bit_sel ? cur_node.right : cur_node.left;

    assign cap_sum      = CAPW'(nodes_used_reg) + CAPW'(rem_reg);
    assign new_idx      = nodes_used_reg[NW-1:0];
    assign next_new_idx = NW'(nodes_used_reg + CW'(1));

    always_comb begin
        state_next      = state_reg;
        nodes_used_next = nodes_used_reg;
        cursor_next     = cursor_reg;
        root_left_next  = root_left_reg;
        root_right_next = root_right_reg;
        sym_vld_next    = sym_vld_reg;
        m_tvalid_next   = m_tvalid_reg & ~m_tready;
        sym_next        = sym_reg;
        word_next       = word_reg;
        word_sh_next    = word_sh_reg;
        len_next        = len_reg;
        rem_next        = rem_reg;
        bit_next        = bit_reg;
        cur_next        = cur_reg;
        par_next        = par_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        node_raddr      = cursor_reg;
        node_we         = 1'b0;
        node_waddr      = cur_reg;
        node_wdata      = par_reg;
        sym_we          = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    sym_next     = in_symbol;
                    word_next    = in_code_word;
                    word_sh_next = in_code_word;
                    len_next     = in_code_length;
                    rem_next     = in_code_length;
                    bit_next     = in_stream_bit;
                    res_next     = '0;
                    case (s_tuser)
                        KIND_ADD: begin
                            cur_next = '0;
                            if (in_bad_add) begin
                                res_next.status = STAT_REJECT;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_WALK;
                            end
                        end
                        KIND_ENC: begin
                            state_next = S_ENC;
                        end
                        KIND_DEC: begin
                            cur_next   = cursor_reg;
                            state_next = S_DEC1;
                        end
                        default: begin
                            // end of message
                            res_next.status = (cursor_reg != '0) ? STAT_LEFTOVER : STAT_OK;
                            cursor_next     = '0;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_ENC: begin
                if (sym_in_range && sym_vld_reg[sym_idx]) begin
                    res_next.out_code_word   = sym_rdata_reg.code;
                    res_next.out_code_length = sym_rdata_reg.len;
                end else begin
                    res_next.status = STAT_UNCODED;
                end
                state_next = S_DONE;
            end
            S_DEC1: begin
                if (child == '0) begin
                    res_next.status = STAT_BADPATH;
                    cursor_next     = '0;
                    state_next      = S_DONE;
                end else begin
                    cur_next   = child;
                    node_raddr = child;
                    state_next = S_DEC2;
                end
            end
            S_DEC2: begin
                if (node_rdata_reg.leaf) begin
                    res_next.symbol_valid = 1'b1;
                    res_next.out_symbol   = node_rdata_reg.sym;
                    cursor_next           = '0;
                end else begin
                    cursor_next = cur_reg;
                end
                state_next = S_DONE;
            end
            S_WALK: begin
                // one tree level per cycle along the existing path
                if (rem_reg == '0 || cur_node.leaf) begin
                    res_next.status = STAT_REJECT;
                    state_next      = S_DONE;
                end else if (child == '0) begin
                    par_next   = cur_node;
                    state_next = S_CAP;
                end else begin
                    cur_next     = child;
                    node_raddr   = child;
                    word_sh_next = {1'b0, word_sh_reg[CODE_W-1:1]};
                    rem_next     = rem_reg - LEN_W'(1);
                end
            end
            S_CAP: begin
                if (cap_sum > CAPW'(NODE_COUNT)) begin
                    res_next.status = STAT_REJECT;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_LINK;
                end
            end
            S_LINK: begin
                // hook the first new node under the last existing one
                if (cur_reg == '0) begin
                    if (word_sh_reg[0]) begin
                        root_right_next = new_idx;
                    end else begin
                        root_left_next = new_idx;
                    end
                end else begin
                    node_we = 1'b1;
                    if (word_sh_reg[0]) begin
                        node_wdata.right = new_idx;
                    end else begin
                        node_wdata.left = new_idx;
                    end
                end
                state_next = S_BUILD;
            end
            S_BUILD: begin
                // new nodes are consecutive: each one but the last (the leaf) points at the next
                node_we         = 1'b1;
                node_waddr      = new_idx;
                node_wdata      = '0;
                nodes_used_next = nodes_used_reg + CW'(1);
                word_sh_next    = {1'b0, word_sh_reg[CODE_W-1:1]};
                rem_next        = rem_reg - LEN_W'(1);
                if (rem_reg == LEN_W'(1)) begin
                    node_wdata.leaf       = 1'b1;
                    node_wdata.sym        = sym_reg;
                    sym_we                = 1'b1;
                    sym_vld_next[sym_idx] = 1'b1;
                    res_next.status       = STAT_OK;
                    state_next            = S_DONE;
                end else if (word_sh_reg[1]) begin
                    node_wdata.right = next_new_idx;
                end else begin
                    node_wdata.left = next_new_idx;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            nodes_used_reg <= CW'(1);
            cursor_reg     <= '0;
            root_left_reg  <= '0;
            root_right_reg <= '0;
            sym_vld_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            nodes_used_reg <= nodes_used_next;
            cursor_reg     <= cursor_next;
            root_left_reg  <= root_left_next;
            root_right_reg <= root_right_next;
            sym_vld_reg    <= sym_vld_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg     <= sym_next;
        word_reg    <= word_next;
        word_sh_reg <= word_sh_next;
        len_reg     <= len_next;
        rem_reg     <= rem_next;
        bit_reg     <= bit_next;
        cur_reg     <= cur_next;
        par_reg     <= par_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rdata_reg <= node_mem[node_raddr];
    end

    always_ff @(posedge aclk) begin
        if (sym_we) begin
            sym_mem[sym_idx] <= '{code: word_reg, len: len_reg};
        end
        sym_rdata_reg <= sym_mem[sym_raddr];
    end

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (nodes_used_reg != '0) && (nodes_used_reg <= CW'(NODE_COUNT)))
        else $error("node fill count out of range");

    a_root_not_written: assert property (@(posedge aclk) disable iff (!aresetn)
        node_we |-> (node_waddr != '0))
        else $error("node table write hit the root slot");

    a_cursor_allocated: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(cursor_reg) < nodes_used_reg)
        else $error("decode cursor points past allocated nodes");

    a_build_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BUILD) |-> (nodes_used_reg < CW'(NODE_COUNT)))
        else $error("node allocation past table end");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word taken while another is in progress");
`endif

endmodule

>>> verif/tb.sv
// Self-checking stream testbench for the prefix code table codec.
`timescale 1ns / 100ps

module tb;
    import pctc_pkg::*;

    localparam int NODE_COUNT    = 256;
    localparam int MAX_CODE_BITS = 16;
    localparam int SYMBOL_COUNT  = 128;
    // cycles without any handshake on either side before the run is declared hung
    localparam int STALL_LIMIT   = 5000;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AFTER    = 400;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] word;
        logic [LEN_W-1:0]  len;
        logic              sbit;
    } in_word_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;  // [6:0] symbol, [22:7] code_word,
                                           // [27:23] code_length, [28] stream_bit
    logic [S_TUSER_W-1:0]  s_tuser  = '0;  // [1:0] kind
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // [6:0] out_symbol, [22:7] out_code_word,
                                           // [27:23] out_code_length
    logic [M_TUSER_W-1:0]  m_tuser;        // [2:0] status, [3] symbol_valid

    // shadow of the codec: node table, symbol code table and decode cursor
    int                node_left [NODE_COUNT]    = '{default: 0};
    int                node_right[NODE_COUNT]    = '{default: 0};
    bit                node_is_leaf[NODE_COUNT]  = '{default: 1'b0};
    logic [SYM_W-1:0]  node_symbol[NODE_COUNT]   = '{default: '0};
    int                node_fill                 = 1;
    int                walk_node                 = 0;
    logic [CODE_W-1:0] sym_code[SYMBOL_COUNT]    = '{default: '0};
    logic [LEN_W-1:0]  sym_code_len[SYMBOL_COUNT] = '{default: '0};

    in_word_t pending_words[$];
    result_t  expected_results[$];
    in_word_t offered;
    int       pushed_words   = 0;
    int       accepted_words = 0;
    int       results_seen   = 0;
    int       fail_count     = 0;
    int       idle_pct       = 0;   // chance per cycle that an idle burst starts, both sides
    int       send_gap       = 0;
    int       recv_gap       = 0;
    int       hold_left      = 0;
    bit       hold_done      = 1'b0;
    int       idle_cycles    = 0;

    prefix_code_table_codec #(
        .NODE_COUNT   (NODE_COUNT),
        .MAX_CODE_BITS(MAX_CODE_BITS),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Rule insertion: refuse a bad length, walk the existing path, refuse on a leaf on
    // the way, on a path ending on an existing node or on a full table, then append the new nodes.
    function automatic logic [STATUS_W-1:0] insert_code(logic [SYM_W-1:0] sym,
                                                        logic [CODE_W-1:0] word,
                                                        logic [LEN_W-1:0] len);
        int node;
        int nxt;
        int lvl;
        node = 0;
        if (len == 0 || len > MAX_CODE_BITS) return STAT_REJECT;
        for (lvl = 0; lvl < len; lvl++) begin
            if (node_is_leaf[node]) return STAT_REJECT;
            nxt = word[lvl] ? node_right[node] : node_left[node];
            if (nxt == 0) break;
            node = nxt;
        end
        if (lvl == len) return STAT_REJECT;
        if (node_fill + (int'(len) - lvl) > NODE_COUNT) return STAT_REJECT;
        while (lvl < len) begin
            nxt = node_fill;
            node_fill++;
            node_left[nxt]    = 0;
            node_right[nxt]   = 0;
            node_is_leaf[nxt] = 1'b0;
            node_symbol[nxt]  = '0;
            if (word[lvl]) node_right[node] = nxt;
            else node_left[node] = nxt;
            node = nxt;
            lvl++;
        end
        node_is_leaf[node] = 1'b1;
        node_symbol[node]  = sym;
        sym_code[sym]      = word;
        sym_code_len[sym]  = len;
        return STAT_OK;
    endfunction

    function automatic result_t predict_result(in_word_t w);
        result_t r;
        int      nxt;
        r = '0;
        case (w.kind)
            KIND_ADD: r.status = insert_code(w.sym, w.word, w.len);
            KIND_ENC: begin
                if (sym_code_len[w.sym] != 0) begin
                    r.out_code_word   = sym_code[w.sym];
                    r.out_code_length = sym_code_len[w.sym];
                end else begin
                    r.status = STAT_UNCODED;
                end
            end
            KIND_DEC: begin
                nxt = w.sbit ? node_right[walk_node] : node_left[walk_node];
                if (nxt == 0) begin
                    r.status  = STAT_BADPATH;
                    walk_node = 0;
                end else if (node_is_leaf[nxt]) begin
                    r.symbol_valid = 1'b1;
                    r.out_symbol   = node_symbol[nxt];
                    walk_node      = 0;
                end else begin
                    walk_node = nxt;
                end
            end
            default: begin
                // end of message
                if (walk_node != 0) r.status = STAT_LEFTOVER;
                walk_node = 0;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_word(logic [KIND_W-1:0] kind, logic [SYM_W-1:0] sym,
                              logic [CODE_W-1:0] word, logic [LEN_W-1:0] len, logic sbit);
        in_word_t w;
        w.kind = kind;
        w.sym  = sym;
        w.word = word;
        w.len  = len;
        w.sbit = sbit;
        pending_words.push_back(w);
        pushed_words++;
    endtask

    // decode words for the first nbits of a symbol's current code;
    // unused fields carry random junk
    task automatic queue_code_bits(int s, int nbits);
        int i;
        for (i = 0; i < nbits; i++)
            queue_word(KIND_DEC, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom),
                       sym_code[s][i]);
    endtask

    // Stall until the codec has taken everything queued, so the shadow
    // tables match what the next batch is built from.
    task automatic wait_drained();
        while (accepted_words != pushed_words) @(negedge aclk);
    endtask

    task automatic pick_idle();
        case ($urandom_range(0, 3))
            0: idle_pct = 0;
            1: idle_pct = 10;
            2: idle_pct = 25;
            default: idle_pct = 40;
        endcase
    endtask

    // A 16-bit path that steers around leaves, so it keeps growing the tree
    // deeper until the node table runs out.
    function automatic logic [CODE_W-1:0] fresh_path();
        logic [CODE_W-1:0] w;
        int                node;
        int                lvl;
        int                nxt;
        w    = CODE_W'($urandom);
        node = 0;
        for (lvl = 0; lvl < MAX_CODE_BITS; lvl++) begin
            nxt = w[lvl] ? node_right[node] : node_left[node];
            if (nxt != 0 && node_is_leaf[nxt]) begin
                w[lvl] = !w[lvl];
                nxt    = w[lvl] ? node_right[node] : node_left[node];
            end
            if (nxt == 0 || node_is_leaf[nxt]) break;
            node = nxt;
        end
        return w;
    endfunction

    // Mixed traffic built from the current code table: mostly whole
    // messages of valid codes, plus rules, encodes, cut-off codes and noise.
    task automatic plan_traffic(int target, int add_pct);
        int               coded[$];
        int               s;
        int               n;
        int               r;
        logic [LEN_W-1:0] len;
        for (s = 0; s < SYMBOL_COUNT; s++)
            if (sym_code_len[s] != 0) coded.push_back(s);
        if (walk_node != 0)
            queue_word(KIND_EOM, SYM_W'($urandom), CODE_W'($urandom), LEN_W'($urandom),
                       1'($urandom));
        while (pushed_words < target) begin
            r = $urandom_range(0, 99);
            if (r < add_pct) begin
                case ($urandom_range(0, 9))
                    0: len = LEN_W'($urandom_range(0, 31));   // empty and overlong too
                    1, 2: len = LEN_W'($urandom_range(12, 16));
                    default: len = LEN_W'($urandom_range(3, 9));
                endcase
                queue_word(KIND_ADD, SYM_W'($urandom), CODE_W'($urandom), len, 1'($urandom));
            end else begin
                r = $urandom_range(0, 99);
                if (coded.size() == 0 || r < 10) begin
                    queue_word(KIND_W'($urandom), SYM_W'($urandom), CODE_W'($urandom),
                               LEN_W'($urandom), 1'($urandom));
                end else if (r < 65) begin
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        s = coded[$urandom_range(0, coded.size() - 1)];
                        queue_code_bits(s, sym_code_len[s]);
                    end
                    if ($urandom_range(0, 1))
                        queue_word(KIND_EOM, SYM_W'($urandom), CODE_W'($urandom),
                                   LEN_W'($urandom), 1'($urandom));
                end else if (r < 82) begin
                    s = $urandom_range(0, 1) ? coded[$urandom_range(0, coded.size() - 1)]
                                             : $urandom_range(0, SYMBOL_COUNT - 1);
                    queue_word(KIND_ENC, SYM_W'(s), CODE_W'($urandom), LEN_W'($urandom),
                               1'($urandom));
                end else begin
                    // code cut short, then end of message -> leftover bits
                    s = coded[$urandom_range(0, coded.size() - 1)];
                    if (sym_code_len[s] > 1)
                        queue_code_bits(s, $urandom_range(1, sym_code_len[s] - 1));
                    queue_word(KIND_EOM, SYM_W'($urandom), CODE_W'($urandom),
                               LEN_W'($urandom), 1'($urandom));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: one word in flight on s_*, held until s_tready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_result(offered));
                accepted_words++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
                    send_gap = $urandom_range(0, 4);
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    offered = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, offered.sbit, offered.len, offered.word, offered.sym};
                    s_tuser  <= offered.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor and receiver: checks each result word, drives m_tready
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'({m_tuser, m_tdata[27:0]});
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected: %h", got);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("symbol_valid", want.symbol_valid, got.symbol_valid);
                    check_field("out_symbol", want.out_symbol, got.out_symbol);
                    check_field("out_code_word", want.out_code_word, got.out_code_word);
                    check_field("out_code_length", want.out_code_length, got.out_code_length);
                end
            end
            // one long hold-off so the codec fills up and drops s_tready
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                recv_gap = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog: nothing moving on either side for too long means a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int tries;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty tree, rule rejects, prefix conflicts, extremes,
        // decode paths, leftover bits, re-added symbol keeping its old leaf
        idle_pct = 20;
        queue_word(KIND_EOM, 7'd0, 16'h0000, 5'd0, 1'b0);       // end at root: ok
        queue_word(KIND_DEC, 7'd127, 16'hFFFF, 5'd31, 1'b0);    // no child on empty tree
        queue_word(KIND_ENC, 7'd0, 16'h0000, 5'd0, 1'b0);       // uncoded
        queue_word(KIND_ADD, 7'd5, 16'h0000, 5'd0, 1'b0);       // empty code
        queue_word(KIND_ADD, 7'd5, 16'hFFFF, 5'd17, 1'b0);      // overlong
        queue_word(KIND_ADD, 7'd5, 16'h0000, 5'd31, 1'b1);      // overlong, max field
        queue_word(KIND_ADD, 7'h41, 16'h0000, 5'd2, 1'b0);      // "00"
        queue_word(KIND_ADD, 7'h42, 16'h0002, 5'd2, 1'b0);      // "01"
        queue_word(KIND_ADD, 7'h43, 16'h0000, 5'd3, 1'b0);      // runs through leaf "00"
        queue_word(KIND_ADD, 7'h44, 16'h0000, 5'd1, 1'b0);      // ends on inner node
        queue_word(KIND_ADD, 7'd127, 16'hFFFF, 5'd16, 1'b1);    // longest, all ones
        queue_word(KIND_ADD, 7'd0, 16'h7FFF, 5'd16, 1'b0);      // branches off at the bottom
        queue_word(KIND_ENC, 7'd127, 16'h0000, 5'd0, 1'b1);
        queue_word(KIND_ENC, 7'd0, 16'hFFFF, 5'd31, 1'b0);
        queue_word(KIND_DEC, 7'd0, 16'h0000, 5'd0, 1'b0);       // inner node
        queue_word(KIND_DEC, 7'd0, 16'h0000, 5'd0, 1'b0);       // leaf 'A'
        queue_word(KIND_DEC, 7'd0, 16'h0000, 5'd0, 1'b1);
        queue_word(KIND_EOM, 7'd0, 16'h0000, 5'd0, 1'b0);       // leftover bits
        queue_word(KIND_DEC, 7'd0, 16'h0000, 5'd0, 1'b1);
        queue_word(KIND_DEC, 7'd0, 16'h0000, 5'd0, 1'b0);       // missing branch
        queue_word(KIND_ADD, 7'h41, 16'h0001, 5'd2, 1'b0);      // re-add 'A' as "10"
        queue_word(KIND_ENC, 7'h41, 16'h0000, 5'd0, 1'b0);      // new code
        queue_word(KIND_DEC, 7'd0, 16'h0000, 5'd0, 1'b0);
        queue_word(KIND_DEC, 7'd0, 16'h0000, 5'd0, 1'b0);       // old leaf still 'A'
        wait_drained();

        // growth: many rules mixed with traffic
        while (pushed_words < 500) begin
            pick_idle();
            plan_traffic(pushed_words + 30, 35);
            wait_drained();
        end

        // fill the node table with deep codes, then run into the full table
        tries = 0;
        while (node_fill < NODE_COUNT - 2 && tries < 60) begin
            queue_word(KIND_ADD, SYM_W'($urandom), fresh_path(), LEN_W'(MAX_CODE_BITS),
                       1'($urandom));
            wait_drained();
            tries++;
        end
        repeat (3) begin
            queue_word(KIND_ADD, SYM_W'($urandom), fresh_path(), LEN_W'(MAX_CODE_BITS),
                       1'($urandom));
            wait_drained();
        end

        // steady decode-heavy traffic
        while (pushed_words < 1500) begin
            pick_idle();
            plan_traffic(pushed_words + 30, 10);
            wait_drained();
        end

        // last stretch at full rate
        idle_pct = 0;
        while (pushed_words < 1700) begin
            plan_traffic(pushed_words + 30, 10);
            wait_drained();
        end

        while (expected_results.size() != 0) @(negedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
